// ----- rtl/erm_pkg.sv -----
// Shared widths, codes and control types of the echo ranging median filter.
package erm_pkg;

  localparam int SID_BITS  = 2;
  localparam int TIME_BITS = 32;
  localparam int CFG_BITS  = 32;
  localparam int DIST_BITS = 27;
  localparam int REP_BITS  = 9;
  localparam int LOW_BITS  = 16;

  localparam logic [CFG_BITS-1:0] TIMER_TOP_RESET = 32'd65535;

  localparam logic ACT_TRIGGER = 1'b0;

  // The factor 17/1000 is taken as (16 + 1), then a shift by 3 and a division by 125.
  localparam int SCALE_SHIFT = 4;
  localparam int DIV_SHIFT   = 3;
  localparam int DIV_ODD     = 125;

  localparam logic [LOW_BITS-1:0] REP_MAX   = 16'd500;
  localparam logic [LOW_BITS-1:0] REP_MIN   = 16'd1;
  localparam logic [REP_BITS-1:0] REP_SUBST = 9'd51;

  typedef struct packed {
    logic load;
    logic arm;
    logic store_rise;
    logic calc_width;
    logic mul_sum;
    logic mul_prod;
    logic quot;
    logic prod;
    logic corr;
    logic ring_write;
    logic k_clr;
    logic read;
    logic rank;
    logic load_out;
  } erm_cmd_t;

  typedef struct packed {
    logic id_ok;
    logic action;
    logic armed;
    logic rise_seen;
    logic k_last;
    logic out_free;
  } erm_stat_t;

endpackage

// ----- rtl/erm_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface erm_in_if import erm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [SID_BITS-1:0]  sensor_id;
  logic [TIME_BITS-1:0] capture_time;

  modport source(output valid, action, sensor_id, capture_time, input ready);
  modport sink(input valid, action, sensor_id, capture_time, output ready);
endinterface

interface erm_out_if import erm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SID_BITS-1:0]  channel;
  logic [DIST_BITS-1:0] raw_distance;
  logic [DIST_BITS-1:0] filtered_distance;
  logic [REP_BITS-1:0]  reported_distance;
  logic                 out_of_range;

  modport source(output valid, channel, raw_distance, filtered_distance,
                 reported_distance, out_of_range, input ready);
  modport sink(input valid, channel, raw_distance, filtered_distance,
               reported_distance, out_of_range, output ready);
endinterface

// ----- rtl/erm_ctrl.sv -----
// Sequencing state machine of the echo ranging median filter.
module erm_ctrl import erm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  erm_stat_t stat_i,
  output erm_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_SUM,
    ST_MUL_PROD,
    ST_QUOT,
    ST_PROD,
    ST_CORR,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_RANK,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    item_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        priority if (!stat_i.id_ok) begin
          state_d = ST_IDLE;
        end else if (stat_i.action == ACT_TRIGGER) begin
          cmd_o.arm = 1'b1;
        end else if (!stat_i.armed) begin
          state_d = ST_IDLE;
        end else if (!stat_i.rise_seen) begin
          cmd_o.store_rise = 1'b1;
        end else begin
          cmd_o.calc_width = 1'b1;
          state_d          = ST_MUL_SUM;
        end
      end
      ST_MUL_SUM: begin
        cmd_o.mul_sum = 1'b1;
        state_d       = ST_MUL_PROD;
      end
      ST_MUL_PROD: begin
        cmd_o.mul_prod = 1'b1;
        state_d        = ST_QUOT;
      end
      ST_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_CORR;
      end
      ST_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.ring_write = 1'b1;
        cmd_o.k_clr      = 1'b1;
        state_d          = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        if (stat_i.k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.k_clr = 1'b1;
        state_d     = ST_RANK;
      end
      ST_RANK: begin
        cmd_o.rank = 1'b1;
        if (stat_i.k_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/erm_dp.sv -----
// Datapath: sensor state, width and distance arithmetic, ring memory, median and result register.
module erm_dp import erm_pkg::*; #(
  parameter int SENSOR_COUNT  = 4,
  parameter int WINDOW_LENGTH = 5,
  parameter int COUNTER_BITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_BITS-1:0]  cfg_wdata_i,
  input  erm_cmd_t             cmd_i,
  output erm_stat_t            stat_o,
  input  logic                 item_action_i,
  input  logic [SID_BITS-1:0]  item_sid_i,
  input  logic [TIME_BITS-1:0] item_time_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [SID_BITS-1:0]  out_channel_o,
  output logic [DIST_BITS-1:0] out_raw_o,
  output logic [DIST_BITS-1:0] out_filt_o,
  output logic [REP_BITS-1:0]  out_rep_o,
  output logic                 out_oor_o
);

  localparam int CB    = COUNTER_BITS;
  localparam int MB    = CB + 2;
  localparam int RB    = CB - 4;
  localparam int QB    = CB - 4;
  localparam int PLW   = CB + RB;
  localparam int FW    = MB + RB;
  localparam int DEPTH = SENSOR_COUNT * WINDOW_LENGTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIW   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int PW    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int KW    = $clog2(WINDOW_LENGTH + 1);
  localparam int MID   = WINDOW_LENGTH / 2;

  localparam logic [63:0]   RECIP_FULL = (64'd1 << MB) / 64'(DIV_ODD);
  localparam logic [RB-1:0] RECIP      = RECIP_FULL[RB-1:0];

  logic [CFG_BITS-1:0]  timer_top_q;
  logic                 act_q;
  logic [SID_BITS-1:0]  sid_q;
  logic [CB-1:0]        time_q;
  logic [SENSOR_COUNT-1:0] armed_q;
  logic [SENSOR_COUNT-1:0] rise_q;
  logic [CB-1:0]        rise_time_q [SENSOR_COUNT];
  logic [PW-1:0]        pos_q [SENSOR_COUNT];
  logic [CB-1:0]        width_q;
  logic [MB-1:0]        m_q;
  logic [PLW-1:0]       plo_q;
  logic [QB-1:0]        q0_q;
  logic [MB-1:0]        p125_q;
  logic [DIST_BITS-1:0] raw_q;
  logic [DIST_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     vld_q;
  logic [DIST_BITS-1:0] rdata_q;
  logic                 rvld_q;
  logic                 cap_en_q;
  logic [PW-1:0]        cap_idx_q;
  logic [DIST_BITS-1:0] win_q [WINDOW_LENGTH];
  logic [KW-1:0]        k_q;
  logic [DIST_BITS-1:0] med_q;
  logic                 out_valid_q;

  logic [SIW+SID_BITS-1:0] sid_ext;
  logic [SIW-1:0]       sidx;
  logic [4:0]           sid_wide;
  logic [CB-1:0]        rt;
  logic [CB-1:0]        top;
  logic [CB-1:0]        width_d;
  logic [CB+4:0]        x_sum;
  logic [FW-1:0]        hi_part;
  logic [FW-1:0]        full_prod;
  logic [MB-1:0]        rem;
  logic [QB-1:0]        qfix;
  logic [DIST_BITS+QB-1:0] raw_ext;
  logic [PW-1:0]        ring_idx;
  logic [31:0]          ring_addr_full;
  logic [AW-1:0]        ring_addr;
  logic [PW-1:0]        pos_cur;
  logic [DIST_BITS-1:0] cand;
  logic [WINDOW_LENGTH-1:0] lt_vec;
  logic [WINDOW_LENGTH-1:0] le_vec;
  logic [KW-1:0]        lt_cnt;
  logic [KW-1:0]        le_cnt;
  logic [LOW_BITS-1:0]  low16;
  logic                 oor;

  assign sid_ext  = {{SIW{1'b0}}, sid_q};
  assign sidx     = sid_ext[SIW-1:0];
  assign sid_wide = {3'b000, sid_q};
  assign rt       = rise_time_q[sidx];
  assign top      = timer_top_q[CB-1:0];
  assign pos_cur  = pos_q[sidx];

  assign stat_o.id_ok     = sid_wide < 5'(SENSOR_COUNT);
  assign stat_o.action    = act_q;
  assign stat_o.armed     = armed_q[sidx];
  assign stat_o.rise_seen = rise_q[sidx];
  assign stat_o.k_last    = k_q == KW'(WINDOW_LENGTH - 1);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_top_q <= TIMER_TOP_RESET;
    end else if (cfg_we_i) begin
      timer_top_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= item_action_i;
      sid_q  <= item_sid_i;
      time_q <= item_time_i[CB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      rise_q  <= '0;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        rise_time_q[s] <= '0;
        pos_q[s]       <= '0;
      end
    end else begin
      if (cmd_i.arm) begin
        armed_q[sidx] <= 1'b1;
        rise_q[sidx]  <= 1'b0;
      end
      if (cmd_i.store_rise) begin
        rise_time_q[sidx] <= time_q;
        rise_q[sidx]      <= 1'b1;
      end
      if (cmd_i.ring_write) begin
        armed_q[sidx] <= 1'b0;
        rise_q[sidx]  <= 1'b0;
        pos_q[sidx]   <= (pos_cur == PW'(WINDOW_LENGTH - 1)) ? '0 : pos_cur + 1'b1;
      end
    end
  end

  // Pulse width, then floor(width * 17 / 1000) by a reciprocal multiply and one correction.
  assign width_d   = (time_q > rt) ? time_q - rt : top - rt + time_q;
  assign x_sum     = {1'b0, width_q, {SCALE_SHIFT{1'b0}}} + {5'b00000, width_q};
  assign hi_part   = FW'(m_q[MB-1:CB]) * FW'(RECIP);
  assign full_prod = FW'(plo_q) + (hi_part << CB);
  assign rem       = m_q - p125_q;
  assign qfix      = (rem >= MB'(DIV_ODD)) ? q0_q + QB'(1) : q0_q;
  assign raw_ext   = {{DIST_BITS{1'b0}}, qfix};

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_width) begin
      width_q <= width_d;
    end
    if (cmd_i.mul_sum) begin
      m_q <= x_sum[CB+4:DIV_SHIFT];
    end
    if (cmd_i.mul_prod) begin
      plo_q <= PLW'(m_q[CB-1:0]) * PLW'(RECIP);
    end
    if (cmd_i.quot) begin
      q0_q <= full_prod[FW-1:MB];
    end
    if (cmd_i.prod) begin
      p125_q <= MB'(q0_q) * MB'(DIV_ODD);
    end
    if (cmd_i.corr) begin
      raw_q <= raw_ext[DIST_BITS-1:0];
    end
  end

  assign ring_idx       = cmd_i.ring_write ? pos_cur : k_q[PW-1:0];
  assign ring_addr_full = 32'(sidx) * 32'(WINDOW_LENGTH) + 32'(ring_idx);
  assign ring_addr      = ring_addr_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_write) begin
      mem[ring_addr] <= raw_q;
    end
    rdata_q <= mem[ring_addr];
    rvld_q  <= vld_q[ring_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      cap_en_q  <= 1'b0;
      cap_idx_q <= '0;
      k_q       <= '0;
    end else begin
      if (cmd_i.ring_write) begin
        vld_q[ring_addr] <= 1'b1;
      end
      cap_en_q  <= cmd_i.read;
      cap_idx_q <= k_q[PW-1:0];
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.read || cmd_i.rank) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_en_q) begin
      win_q[cap_idx_q] <= rvld_q ? rdata_q : '0;
    end
  end

  // A candidate is the median when it covers the middle rank of the sorted window.
  assign cand = win_q[k_q[PW-1:0]];

  always_comb begin
    for (int j = 0; j < WINDOW_LENGTH; j++) begin
      lt_vec[j] = win_q[j] < cand;
      le_vec[j] = win_q[j] <= cand;
    end
  end

  assign lt_cnt = KW'($countones(lt_vec));
  assign le_cnt = KW'($countones(le_vec));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rank && (lt_cnt <= KW'(MID)) && (KW'(MID) < le_cnt)) begin
      med_q <= cand;
    end
  end

  assign low16 = med_q[LOW_BITS-1:0];
  assign oor   = (low16 > REP_MAX) || (low16 <= REP_MIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_channel_o <= sid_q;
      out_raw_o     <= raw_q;
      out_filt_o    <= med_q;
      out_rep_o     <= oor ? REP_SUBST : low16[REP_BITS-1:0];
      out_oor_o     <= oor;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/echo_ranging_median_filter_unit.sv -----
// Top level of the echo ranging median filter: controller, datapath and channel ports.
// A trigger or a first edge passes only through the IDLE and DECODE states.
// A completing edge goes on through MUL_SUM, MUL_PROD, QUOT, PROD, CORR, WRITE, READ,
// DRAIN, RANK and EMIT, with a one-entry-a-cycle read of the ring memory port and a
// one-candidate-a-cycle median rank; EMIT waits until the result register is free.
// Reset clears all sensor state and the ring valid bits at once; no clearing pass is needed.
module echo_ranging_median_filter_unit import erm_pkg::*; #(
  parameter int SENSOR_COUNT  = 4,
  parameter int WINDOW_LENGTH = 5,
  parameter int COUNTER_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i,
  erm_in_if.sink              item_i,
  erm_out_if.source           result_o
);

  erm_cmd_t  cmd;
  erm_stat_t stat;

  erm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  erm_dp #(
    .SENSOR_COUNT  (SENSOR_COUNT),
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .item_action_i (item_i.action),
    .item_sid_i    (item_i.sensor_id),
    .item_time_i   (item_i.capture_time),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .out_channel_o (result_o.channel),
    .out_raw_o     (result_o.raw_distance),
    .out_filt_o    (result_o.filtered_distance),
    .out_rep_o     (result_o.reported_distance),
    .out_oor_o     (result_o.out_of_range)
  );

`ifndef SYNTHESIS
  // The block holds one item at a time, so a transfer closes the input for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("input accepted a second item while one was in work");

  // A result only ever names a sensor that exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (32'(result_o.channel) < SENSOR_COUNT))
    else $error("result names a sensor beyond the sensor count");

  // The out-of-range flag and the reported value agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.out_of_range ? (result_o.reported_distance == REP_SUBST)
      : ((result_o.reported_distance > 9'd1) && (result_o.reported_distance <= 9'd500))))
    else $error("reported distance does not match the out-of-range flag");

  // The datapath never loads a new result over one that has not been transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |=> result_o.valid)
    else $error("pending result was dropped");
`endif

endmodule

// ----- tb/echo_ranging_median_filter_unit_tb.sv -----
// Self-checking testbench for the echo ranging median filter: directed rows, then random pulses mixed with noise items.
module echo_ranging_median_filter_unit_tb;
  import erm_pkg::*;

  localparam int SENSORS       = 4;
  localparam int WINDOW        = 5;
  localparam int PHASE_ITEMS   = 96;
  localparam int SETTLE_CYCLES = 2 * WINDOW + 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic ACT_EDGE    = ~ACT_TRIGGER;

  typedef struct packed {
    logic                 action;
    logic [SID_BITS-1:0]  sensor;
    logic [TIME_BITS-1:0] stamp;
  } echo_item_t;

  typedef struct packed {
    logic [SID_BITS-1:0]  channel;
    logic [DIST_BITS-1:0] raw;
    logic [DIST_BITS-1:0] filtered;
    logic [REP_BITS-1:0]  reported;
    logic                 oor;
  } reading_t;

  typedef struct packed {
    echo_item_t item;
    logic       typed;
    reading_t   want;
  } stim_row_t;

  localparam int DIR_COUNT = 24;
  localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
    '{'{ACT_EDGE,    2'd0, 32'd1234},        1'b0, '0},
    '{'{ACT_TRIGGER, 2'd0, 32'hA5A5_5A5A},   1'b0, '0},
    '{'{ACT_EDGE,    2'd0, 32'd0},           1'b0, '0},
    '{'{ACT_EDGE,    2'd0, 32'd1000},        1'b1, '{2'd0, 27'd17, 27'd0, 9'd51, 1'b1}},
    '{'{ACT_TRIGGER, 2'd1, 32'h5A5A_A5A5},   1'b0, '0},
    '{'{ACT_EDGE,    2'd1, 32'd100},         1'b0, '0},
    '{'{ACT_TRIGGER, 2'd1, 32'hFFFF_FFFF},   1'b0, '0},
    '{'{ACT_EDGE,    2'd1, 32'd5},           1'b0, '0},
    '{'{ACT_EDGE,    2'd1, 32'd5},           1'b1, '{2'd1, 27'd1114, 27'd0, 9'd51, 1'b1}},
    '{'{ACT_TRIGGER, 2'd2, 32'd0},           1'b0, '0},
    '{'{ACT_EDGE,    2'd2, 32'd0},           1'b0, '0},
    '{'{ACT_EDGE,    2'd2, 32'hFFFF_FFFF},   1'b1, '{2'd2, 27'd73014444, 27'd0, 9'd51, 1'b1}},
    '{'{ACT_TRIGGER, 2'd3, 32'd7},           1'b0, '0},
    '{'{ACT_EDGE,    2'd3, 32'hFFFF_FFFF},   1'b0, '0},
    '{'{ACT_EDGE,    2'd3, 32'd0},           1'b0, '0},
    '{'{ACT_TRIGGER, 2'd0, 32'd0},           1'b0, '0},
    '{'{ACT_EDGE,    2'd0, 32'd0},           1'b0, '0},
    '{'{ACT_EDGE,    2'd0, 32'd29412},       1'b0, '0},
    '{'{ACT_TRIGGER, 2'd0, 32'd0},           1'b0, '0},
    '{'{ACT_EDGE,    2'd0, 32'd0},           1'b0, '0},
    '{'{ACT_EDGE,    2'd0, 32'd29412},       1'b0, '0},
    '{'{ACT_TRIGGER, 2'd0, 32'd0},           1'b0, '0},
    '{'{ACT_EDGE,    2'd0, 32'd0},           1'b0, '0},
    '{'{ACT_EDGE,    2'd0, 32'd29471},       1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_BITS-1:0] cfg_wdata_i;

  erm_in_if  item_if();
  erm_out_if result_if();

  echo_ranging_median_filter_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  logic [CFG_BITS-1:0]  cur_top;
  logic                 armed      [SENSORS];
  logic                 rise_seen  [SENSORS];
  logic [TIME_BITS-1:0] rise_stamp [SENSORS];
  logic [DIST_BITS-1:0] dist_hist  [SENSORS][WINDOW];
  int                   hist_wr    [SENSORS];

  reading_t expected_readings [$];
  int       err_count;
  int       hold_len;
  bit       no_gaps;
  int       burst_left;
  int       cycle_count;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic logic [DIST_BITS-1:0] window_median(input int s);
    logic [DIST_BITS-1:0] w [WINDOW];
    logic [DIST_BITS-1:0] v;
    int                   b;
    for (int a = 0; a < WINDOW; a++) w[a] = dist_hist[s][a];
    for (int a = 1; a < WINDOW; a++) begin
      v = w[a];
      b = a;
      while (b > 0 && w[b-1] > v) begin
        w[b] = w[b-1];
        b--;
      end
      w[b] = v;
    end
    return w[WINDOW/2];
  endfunction

  task automatic predict_ranging(input echo_item_t it, input logic typed, input reading_t want);
    logic [TIME_BITS-1:0] width;
    logic [DIST_BITS-1:0] raw;
    logic [DIST_BITS-1:0] med;
    reading_t             calc;
    int                   s;
    s = int'(it.sensor);
    if (it.action == ACT_TRIGGER) begin
      armed[s]     = 1'b1;
      rise_seen[s] = 1'b0;
    end else if (armed[s] && !rise_seen[s]) begin
      rise_stamp[s] = it.stamp;
      rise_seen[s]  = 1'b1;
    end else if (armed[s]) begin
      if (it.stamp > rise_stamp[s]) begin
        width = it.stamp - rise_stamp[s];
      end else begin
        width = cur_top - rise_stamp[s] + it.stamp;
      end
      raw = DIST_BITS'((64'(width) * 64'd17) / 64'd1000);
      dist_hist[s][hist_wr[s]] = raw;
      hist_wr[s] = (hist_wr[s] == WINDOW - 1) ? 0 : hist_wr[s] + 1;
      med = window_median(s);
      armed[s]     = 1'b0;
      rise_seen[s] = 1'b0;
      calc.channel  = it.sensor;
      calc.raw      = raw;
      calc.filtered = med;
      if (med[LOW_BITS-1:0] > REP_MAX || med[LOW_BITS-1:0] <= REP_MIN) begin
        calc.reported = REP_SUBST;
        calc.oor      = 1'b1;
      end else begin
        calc.reported = REP_BITS'(med[LOW_BITS-1:0]);
        calc.oor      = 1'b0;
      end
      expected_readings.push_back(typed ? want : calc);
    end
  endtask

  task automatic pace();
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic offer(input echo_item_t it, input logic typed, input reading_t want);
    item_if.valid        <= 1'b1;
    item_if.action       <= it.action;
    item_if.sensor_id    <= it.sensor;
    item_if.capture_time <= it.stamp;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    predict_ranging(it, typed, want);
    pace();
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_top(input logic [CFG_BITS-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_top = value;
  endtask

  task automatic random_pulse(input int cat);
    int unsigned          raw;
    logic [TIME_BITS-1:0] w;
    logic [TIME_BITS-1:0] rise;
    logic [TIME_BITS-1:0] fall;
    logic [SID_BITS-1:0]  s;
    s = SID_BITS'($urandom_range(0, SENSORS - 1));
    case (cat)
      0: raw = $urandom_range(0, 3);
      1: raw = $urandom_range(490, 510);
      2: raw = $urandom_range(0, 600);
      3: raw = $urandom_range(1, 1100) * 65536 + $urandom_range(0, 600);
      default: raw = 0;
    endcase
    if (cat == 4) begin
      rise = $urandom;
      fall = $urandom;
    end else if (cat == 5) begin
      rise = $urandom;
      fall = ($urandom_range(0, 3) == 0) ? rise : $urandom_range(0, rise);
    end else begin
      w = TIME_BITS'((64'(raw) * 64'd1000 + 64'd16) / 64'd17);
      if (w == '0) w = 1;
      rise = $urandom_range(0, 32'hFFFF_FFFF - w);
      fall = rise + w;
    end
    offer('{ACT_TRIGGER, s, TIME_BITS'($urandom)}, 1'b0, '0);
    offer('{ACT_EDGE, s, rise}, 1'b0, '0);
    offer('{ACT_EDGE, s, fall}, 1'b0, '0);
  endtask

  task automatic random_noise();
    logic [SID_BITS-1:0] s;
    s = SID_BITS'($urandom_range(0, SENSORS - 1));
    case ($urandom_range(0, 2))
      0: offer('{1'($urandom_range(0, 1)), s, TIME_BITS'($urandom)}, 1'b0, '0);
      1: begin
        offer('{ACT_TRIGGER, s, TIME_BITS'($urandom)}, 1'b0, '0);
        offer('{ACT_EDGE, s, TIME_BITS'($urandom)}, 1'b0, '0);
      end
      default: offer('{ACT_EDGE, s, TIME_BITS'($urandom)}, 1'b0, '0);
    endcase
  endtask

  task automatic run_phase(input logic [CFG_BITS-1:0] top, input int cat, input bit steady,
                           input bit hold, input bit midpause);
    int sent;
    bit paused;
    write_top(top);
    no_gaps    = steady;
    burst_left = $urandom_range(1, 20);
    if (hold) hold_len = HOLD_CYCLES;
    sent   = 0;
    paused = 0;
    while (sent < PHASE_ITEMS) begin
      if (midpause && !paused && sent >= PHASE_ITEMS / 2) begin
        settle();
        paused = 1;
      end
      if ($urandom_range(0, 99) < 15) begin
        random_noise();
      end else begin
        random_pulse(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : cat);
        sent += 3;
      end
    end
  endtask

  initial begin
    item_if.valid        <= 1'b0;
    item_if.action       <= ACT_TRIGGER;
    item_if.sensor_id    <= '0;
    item_if.capture_time <= '0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    rst_ni               <= 1'b0;
    err_count  = 0;
    hold_len   = 0;
    no_gaps    = 0;
    burst_left = 4;
    cur_top    = TIMER_TOP_RESET;
    for (int s = 0; s < SENSORS; s++) begin
      armed[s]      = 1'b0;
      rise_seen[s]  = 1'b0;
      rise_stamp[s] = '0;
      hist_wr[s]    = 0;
      for (int k = 0; k < WINDOW; k++) dist_hist[s][k] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < DIR_COUNT; r++) begin
      offer(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end
    run_phase(32'd1,                           0, 1'b0, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF,                   1, 1'b1, 1'b1, 1'b0);
    run_phase($urandom_range(2, 32'hFFFF_FFFF), 2, 1'b1, 1'b0, 1'b0);
    run_phase(TIMER_TOP_RESET,                 3, 1'b0, 1'b0, 1'b1);
    run_phase($urandom_range(2, 32'hFFFF),     4, 1'b0, 1'b0, 1'b0);
    run_phase(32'd100,                         5, 1'b0, 1'b0, 1'b0);
    settle();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int mode;
    int seg;
    int tick;
    result_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    tick = 0;
    forever begin
      if (hold_len > 0) begin
        result_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        mode = $urandom_range(0, 2);
        seg  = $urandom_range(20, 150);
        repeat (seg) begin
          case (mode)
            0: result_if.ready <= 1'b1;
            1: result_if.ready <= 1'($urandom_range(0, 1));
            default: result_if.ready <= (tick % 4 == 0);
          endcase
          tick++;
          @(posedge clk_i);
          if (hold_len > 0) break;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_readings
    reading_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading on channel %0d", result_if.channel);
        err_count++;
      end else begin
        want = expected_readings.pop_front();
        if (result_if.channel !== want.channel) begin
          $error("channel: expected %0d, got %0d", want.channel, result_if.channel);
          err_count++;
        end
        if (result_if.raw_distance !== want.raw) begin
          $error("raw_distance: expected %0d, got %0d", want.raw, result_if.raw_distance);
          err_count++;
        end
        if (result_if.filtered_distance !== want.filtered) begin
          $error("filtered_distance: expected %0d, got %0d", want.filtered,
                 result_if.filtered_distance);
          err_count++;
        end
        if (result_if.reported_distance !== want.reported) begin
          $error("reported_distance: expected %0d, got %0d", want.reported,
                 result_if.reported_distance);
          err_count++;
        end
        if (result_if.out_of_range !== want.oor) begin
          $error("out_of_range: expected %0d, got %0d", want.oor, result_if.out_of_range);
          err_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
